@@ hw/rtl/affine_tile_background_pixel_top_macros.svh @@
// assertion macros shared by the affine tile background pixel rtl
`ifndef AFFINE_TILE_BACKGROUND_PIXEL_TOP_MACROS_SVH
`define AFFINE_TILE_BACKGROUND_PIXEL_TOP_MACROS_SVH

// condition that holds at every clock edge out of reset
`define ATBP_ASSERT(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("atbp assertion failed");

// consequent checked in the same cycle as the antecedent
`define ATBP_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("atbp assertion failed");

// consequent checked in the cycle after the antecedent
`define ATBP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("atbp assertion failed");

`endif

@@ hw/rtl/atbp_pkg.sv @@
// types, constants and helpers of the affine tile background pixel block
`timescale 1ns / 1ps

package atbp_pkg;

  localparam int VIDEO_BYTES  = 98304;
  localparam int VIDEO_ADDR_W = $clog2(VIDEO_BYTES);
  localparam logic [17:0] VIDEO_LIMIT = 18'(VIDEO_BYTES);
  localparam int SCREEN_WIDTH = 240;
  localparam logic [10:0] SCREEN_LIMIT = 11'(SCREEN_WIDTH);
  localparam int PAL_ENTRIES  = 256;
  localparam int PAL_ADDR_W   = $clog2(PAL_ENTRIES);
  localparam logic [17:0] PAL_LIMIT = 18'(PAL_ENTRIES);

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef enum logic [1:0] {
    CMD_VID_WR = 2'd0,
    CMD_PAL_WR = 2'd1,
    CMD_RENDER = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    OP_VID_WR = 2'd0,
    OP_PAL_WR = 2'd1,
    OP_DRAW   = 2'd2,
    OP_BLANK  = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    REG_BG_CONTROL  = 3'd0,
    REG_LAYER_EN    = 3'd1,
    REG_STEP_X_COL  = 3'd2,
    REG_STEP_X_LINE = 3'd3,
    REG_STEP_Y_COL  = 3'd4,
    REG_STEP_Y_LINE = 3'd5,
    REG_ORIGIN_X    = 3'd6,
    REG_ORIGIN_Y    = 3'd7
  } reg_idx_e;

  typedef struct packed {
    logic [15:0] bg_control;
    logic        layer_enable;
    logic [15:0] step_x_col;
    logic [15:0] step_x_line;
    logic [15:0] step_y_col;
    logic [15:0] step_y_line;
    logic [27:0] origin_x;
    logic [27:0] origin_y;
  } cfg_t;

  typedef struct packed {
    op_e         op;
    logic [16:0] addr;
    logic [15:0] data;
    logic [2:0]  sub_y;
    logic [2:0]  sub_x;
  } q_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  // map side minus one for the size code: 128, 256, 512 or 1024 pixels
  function automatic logic [9:0] side_mask(input logic [1:0] code);
    logic [9:0] m;
    case (code)
      2'd0:    m = 10'd127;
      2'd1:    m = 10'd255;
      2'd2:    m = 10'd511;
      default: m = 10'd1023;
    endcase
    return m;
  endfunction

endpackage

@@ hw/rtl/atbp_ram.sv @@
// generic single write port ram with registered read
`timescale 1ns / 1ps

module atbp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

@@ hw/rtl/atbp_regs.sv @@
// configuration registers behind the apb port
`timescale 1ns / 1ps

module atbp_regs (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           psel,
  input  logic           penable,
  input  logic           pwrite,
  input  logic [4:0]     paddr,
  input  logic [31:0]    pwdata,
  output logic [31:0]    prdata,
  output logic           pready,
  output atbp_pkg::cfg_t cfg_o
);
  import atbp_pkg::*;

  cfg_t     cfg_q, cfg_d;
  reg_idx_e idx;
  logic     wr_en;

  assign idx    = reg_idx_e'(paddr[4:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (idx)
        REG_BG_CONTROL:  cfg_d.bg_control   = pwdata[15:0];
        REG_LAYER_EN:    cfg_d.layer_enable = pwdata[0];
        REG_STEP_X_COL:  cfg_d.step_x_col   = pwdata[15:0];
        REG_STEP_X_LINE: cfg_d.step_x_line  = pwdata[15:0];
        REG_STEP_Y_COL:  cfg_d.step_y_col   = pwdata[15:0];
        REG_STEP_Y_LINE: cfg_d.step_y_line  = pwdata[15:0];
        REG_ORIGIN_X:    cfg_d.origin_x     = pwdata[27:0];
        REG_ORIGIN_Y:    cfg_d.origin_y     = pwdata[27:0];
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_BG_CONTROL:  prdata = {16'b0, cfg_q.bg_control};
      REG_LAYER_EN:    prdata = {31'b0, cfg_q.layer_enable};
      REG_STEP_X_COL:  prdata = {16'b0, cfg_q.step_x_col};
      REG_STEP_X_LINE: prdata = {16'b0, cfg_q.step_x_line};
      REG_STEP_Y_COL:  prdata = {16'b0, cfg_q.step_y_col};
      REG_STEP_Y_LINE: prdata = {16'b0, cfg_q.step_y_line};
      REG_ORIGIN_X:    prdata = {4'b0, cfg_q.origin_x};
      REG_ORIGIN_Y:    prdata = {4'b0, cfg_q.origin_y};
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.bg_control   <= 16'd0;
      cfg_q.layer_enable <= 1'b0;
      cfg_q.step_x_col   <= 16'd256;
      cfg_q.step_x_line  <= 16'd0;
      cfg_q.step_y_col   <= 16'd0;
      cfg_q.step_y_line  <= 16'd256;
      cfg_q.origin_x     <= 28'd0;
      cfg_q.origin_y     <= 28'd0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

@@ hw/rtl/atbp_front.sv @@
// front end: accepts items, forms the texture position and classifies them
`timescale 1ns / 1ps

module atbp_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  atbp_pkg::cfg_t      cfg_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [1:0]          command_i,
  input  logic [16:0]         address_i,
  input  logic [15:0]         write_data_i,
  input  logic [7:0]          scan_line_i,
  input  logic [7:0]          column_i,
  input  atbp_pkg::q_status_t q_status_i,
  output logic                push_o,
  output atbp_pkg::q_entry_t  entry_o
);
  import atbp_pkg::*;

  logic               f_valid_q, f_valid_d;
  logic [1:0]         f_cmd_q;
  logic [16:0]        f_addr_q;
  logic [15:0]        f_data_q;
  logic               f_pass_q;
  logic signed [24:0] p_xl_q, p_xc_q, p_yl_q, p_yc_q;
  logic signed [24:0] p_xl_d, p_xc_d, p_yl_d, p_yc_d;
  logic               accept, keep, hold;

  logic signed [29:0] tx, ty;
  logic [21:0]        fx, fy;
  logic [9:0]         mask, sx, sy;
  logic               in_map, wrap;
  logic [1:0]         size_code;
  logic [2:0]         row_shift;
  logic [16:0]        map_addr;

  assign hold       = f_valid_q && keep && q_status_i.full;
  assign in_stall_o = hold;
  assign accept     = in_valid_i && !in_stall_o;
  assign push_o     = f_valid_q && keep && !q_status_i.full;
  assign f_valid_d  = hold ? 1'b1 : in_valid_i;

  // signed step times unsigned line or column
  always_comb begin
    p_xl_d = 25'($signed(cfg_i.step_x_line)) * 25'($signed({1'b0, scan_line_i}));
    p_xc_d = 25'($signed(cfg_i.step_x_col))  * 25'($signed({1'b0, column_i}));
    p_yl_d = 25'($signed(cfg_i.step_y_line)) * 25'($signed({1'b0, scan_line_i}));
    p_yc_d = 25'($signed(cfg_i.step_y_col))  * 25'($signed({1'b0, column_i}));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f_valid_q <= 1'b0;
    end else begin
      f_valid_q <= f_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      f_cmd_q  <= command_i;
      f_addr_q <= address_i;
      f_data_q <= write_data_i;
      f_pass_q <= cfg_i.layer_enable && ({3'b0, column_i} < SCREEN_LIMIT);
      p_xl_q   <= p_xl_d;
      p_xc_q   <= p_xc_d;
      p_yl_q   <= p_yl_d;
      p_yc_q   <= p_yc_d;
    end
  end

  // texture position, floored by dropping the fraction
  always_comb begin
    size_code = cfg_i.bg_control[15:14];
    wrap      = cfg_i.bg_control[13];
    mask      = side_mask(size_code);
    tx = 30'($signed(cfg_i.origin_x)) + 30'(p_xl_q) + 30'(p_xc_q);
    ty = 30'($signed(cfg_i.origin_y)) + 30'(p_yl_q) + 30'(p_yc_q);
    fx = tx[29:8];
    fy = ty[29:8];
    in_map = !fx[21] && !fy[21]
          && ((fx[20:0] & ~{11'b0, mask}) == 21'b0)
          && ((fy[20:0] & ~{11'b0, mask}) == 21'b0);
    sx = fx[9:0] & mask;
    sy = fy[9:0] & mask;
    row_shift = 3'd4 + {1'b0, size_code};
    map_addr  = {1'b0, cfg_i.bg_control[12:8], 11'b0}
              + (17'(sy[9:3]) << row_shift)
              + 17'(sx[9:3]);
  end

  always_comb begin
    entry_o.addr  = f_addr_q;
    entry_o.data  = f_data_q;
    entry_o.sub_y = sy[2:0];
    entry_o.sub_x = sx[2:0];
    entry_o.op    = OP_BLANK;
    keep          = 1'b0;
    case (cmd_e'(f_cmd_q))
      CMD_VID_WR: begin
        entry_o.op = OP_VID_WR;
        keep       = {1'b0, f_addr_q} < VIDEO_LIMIT;
      end
      CMD_PAL_WR: begin
        entry_o.op = OP_PAL_WR;
        keep       = {1'b0, f_addr_q} < PAL_LIMIT;
      end
      CMD_RENDER: begin
        keep = 1'b1;
        if (f_pass_q && (wrap || in_map)) begin
          entry_o.op   = OP_DRAW;
          entry_o.addr = map_addr;
        end
      end
      default: keep = 1'b0;
    endcase
  end

endmodule

@@ hw/rtl/atbp_queue.sv @@
// short fifo between the front and the back end
`timescale 1ns / 1ps

`include "affine_tile_background_pixel_top_macros.svh"

module atbp_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  atbp_pkg::q_entry_t  entry_i,
  input  logic                pop_i,
  output atbp_pkg::q_status_t status_o,
  output atbp_pkg::q_entry_t  head_o
);
  import atbp_pkg::*;

  q_entry_t            entries_q [QDEPTH];
  logic [QPTR_W-1:0]   wptr_q, rptr_q;
  logic [QCNT_W-1:0]   count_q, count_d;
  logic                do_push, do_pop;

  assign status_o.full  = count_q == QCNT_W'(QDEPTH);
  assign status_o.empty = count_q == '0;
  assign do_push = push_i && !status_o.full;
  assign do_pop  = pop_i && !status_o.empty;
  assign head_o  = entries_q[rptr_q];

  always_comb begin
    count_d = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      count_q <= count_d;
      if (do_push) begin
        wptr_q <= wptr_q + 1'b1;
      end
      if (do_pop) begin
        rptr_q <= rptr_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entries_q[wptr_q] <= entry_i;
    end
  end

  `ATBP_ASSERT(a_no_push_full, clk_i, rst_ni, !(push_i && status_o.full))
  `ATBP_ASSERT(a_no_pop_empty, clk_i, rst_ni, !(pop_i && status_o.empty))
  `ATBP_ASSERT(a_count_bound, clk_i, rst_ni, count_q <= QCNT_W'(QDEPTH))

endmodule

@@ hw/rtl/atbp_back.sv @@
// back end: map, tile and palette lookups in three ram stages and the result register
`timescale 1ns / 1ps

`include "affine_tile_background_pixel_top_macros.svh"

module atbp_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  atbp_pkg::cfg_t      cfg_i,
  input  atbp_pkg::q_status_t q_status_i,
  input  atbp_pkg::q_entry_t  head_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic                opaque_o,
  output logic [15:0]         color_o,
  output logic [1:0]          priority_res_o
);
  import atbp_pkg::*;

  logic adv;

  // stage 1: map byte read
  logic        map_we, map_oob;
  logic [7:0]  map_rdata;
  logic        s1_valid_q;
  op_e         s1_op_q;
  logic [16:0] s1_addr_q;
  logic [15:0] s1_data_q;
  logic [5:0]  s1_sub_q;
  logic        s1_zero_q;

  // stage 2: tile pixel read
  logic [7:0]  tile;
  logic [16:0] tile_addr;
  logic        tile_we, tile_oob;
  logic [7:0]  tile_rdata;
  logic        s2_valid_q;
  op_e         s2_op_q;
  logic [7:0]  s2_pal_q;
  logic [15:0] s2_data_q;
  logic        s2_zero_q;

  // stage 3: palette read
  logic [7:0]  cidx;
  logic        pal_we;
  logic [15:0] pal_rdata;
  logic        s3_res_q, s3_opq_q;

  logic        out_valid_q, opaque_q;
  logic [15:0] color_q;
  logic [1:0]  prio_q;

  // every stage moves together while the result register can take an item
  assign adv   = !out_valid_q || !out_stall_i;
  assign pop_o = adv && !q_status_i.empty;

  assign map_we  = pop_o && (head_i.op == OP_VID_WR);
  assign map_oob = {1'b0, head_i.addr} >= VIDEO_LIMIT;

  atbp_ram #(.WIDTH(8), .DEPTH(VIDEO_BYTES)) u_map_ram (
    .clk_i   (clk_i),
    .we_i    (map_we),
    .waddr_i (head_i.addr[VIDEO_ADDR_W-1:0]),
    .wdata_i (head_i.data[7:0]),
    .re_i    (adv),
    .raddr_i (head_i.addr[VIDEO_ADDR_W-1:0]),
    .rdata_o (map_rdata)
  );

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_op_q   <= head_i.op;
      s1_addr_q <= head_i.addr;
      s1_data_q <= head_i.data;
      s1_sub_q  <= {head_i.sub_y, head_i.sub_x};
      s1_zero_q <= map_oob;
    end
  end

  always_comb begin
    tile      = s1_zero_q ? 8'd0 : map_rdata;
    tile_addr = {1'b0, cfg_i.bg_control[3:2], 14'b0} + 17'({tile, 6'b0}) + 17'(s1_sub_q);
    tile_oob  = {1'b0, tile_addr} >= VIDEO_LIMIT;
    tile_we   = adv && s1_valid_q && (s1_op_q == OP_VID_WR);
  end

  // second copy of video memory so the tile read has its own port
  atbp_ram #(.WIDTH(8), .DEPTH(VIDEO_BYTES)) u_tile_ram (
    .clk_i   (clk_i),
    .we_i    (tile_we),
    .waddr_i (s1_addr_q[VIDEO_ADDR_W-1:0]),
    .wdata_i (s1_data_q[7:0]),
    .re_i    (adv),
    .raddr_i (tile_addr[VIDEO_ADDR_W-1:0]),
    .rdata_o (tile_rdata)
  );

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s2_op_q   <= s1_op_q;
      s2_pal_q  <= s1_addr_q[PAL_ADDR_W-1:0];
      s2_data_q <= s1_data_q;
      s2_zero_q <= tile_oob;
    end
  end

  assign cidx   = s2_zero_q ? 8'd0 : tile_rdata;
  assign pal_we = adv && s2_valid_q && (s2_op_q == OP_PAL_WR);

  atbp_ram #(.WIDTH(16), .DEPTH(PAL_ENTRIES)) u_pal_ram (
    .clk_i   (clk_i),
    .we_i    (pal_we),
    .waddr_i (s2_pal_q),
    .wdata_i (s2_data_q),
    .re_i    (adv),
    .raddr_i (cidx),
    .rdata_o (pal_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      s3_res_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      s1_valid_q  <= !q_status_i.empty;
      s2_valid_q  <= s1_valid_q;
      s3_res_q    <= s2_valid_q && ((s2_op_q == OP_DRAW) || (s2_op_q == OP_BLANK));
      out_valid_q <= s3_res_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s3_opq_q <= (s2_op_q == OP_DRAW) && (cidx != 8'd0);
      opaque_q <= s3_opq_q;
      color_q  <= s3_opq_q ? pal_rdata : 16'd0;
      prio_q   <= s3_opq_q ? cfg_i.bg_control[1:0] : 2'd0;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign opaque_o       = opaque_q;
  assign color_o        = color_q;
  assign priority_res_o = prio_q;

  `ATBP_ASSERT_NEXT(a_freeze, clk_i, rst_ni, !adv, $stable(s1_valid_q) && $stable(s3_res_q))
  `ATBP_ASSERT_IMPL(a_out_from_render, clk_i, rst_ni, $rose(out_valid_q), $past(s3_res_q))
  `ATBP_ASSERT(a_blank_zero, clk_i, rst_ni,
               !(out_valid_q && !opaque_q) || ((color_q == 16'd0) && (prio_q == 2'd0)))

endmodule

@@ hw/rtl/affine_tile_background_pixel_top.sv @@
// top level of the affine tile background pixel renderer
//
//   channel  direction  handshake              payload
//   input    in         in_valid_i/in_stall_o  command_i address_i write_data_i
//                                              scan_line_i column_i
//   result   out        out_valid_o/out_stall_i opaque_o color_o priority_res_o
//   config   in         apb psel/penable/pwrite paddr pwdata prdata pready
//
// one item per clock sustained while the output is not stalled
// a render result passes the position multiply register, the queue and the three ram reads
// in series (map byte, tile pixel, palette word), each with a registered read port
// reset clears control state and the configuration registers only; ram contents and data registers are left as they are
// an output stall freezes the back end; the queue then fills and stalls the input
`timescale 1ns / 1ps

module affine_tile_background_pixel_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  command_i,
  input  logic [16:0] address_i,
  input  logic [15:0] write_data_i,
  input  logic [7:0]  scan_line_i,
  input  logic [7:0]  column_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        opaque_o,
  output logic [15:0] color_o,
  output logic [1:0]  priority_res_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import atbp_pkg::*;

  cfg_t      cfg;
  q_status_t q_status;
  q_entry_t  q_entry, q_head;
  logic      q_push, q_pop;

  atbp_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  atbp_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .command_i    (command_i),
    .address_i    (address_i),
    .write_data_i (write_data_i),
    .scan_line_i  (scan_line_i),
    .column_i     (column_i),
    .q_status_i   (q_status),
    .push_o       (q_push),
    .entry_o      (q_entry)
  );

  atbp_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (q_push),
    .entry_i  (q_entry),
    .pop_i    (q_pop),
    .status_o (q_status),
    .head_o   (q_head)
  );

  atbp_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg),
    .q_status_i     (q_status),
    .head_i         (q_head),
    .pop_o          (q_pop),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .opaque_o       (opaque_o),
    .color_o        (color_o),
    .priority_res_o (priority_res_o)
  );

endmodule
